// ----- sv/utf16sv_pkg.sv -----
// ----------------------------------------------------------------------------
// utf16sv_pkg
// Shared types, codes and helper functions of the UTF-16 stream validator.
// ----------------------------------------------------------------------------
package utf16sv_pkg;

    // Width of the internal saturating counters
    localparam int COUNT_WIDTH = 32;
    // Width of the count fields on the result channel
    localparam int OUT_COUNT_WIDTH = 32;
    localparam int CMP_WIDTH = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH
                                                               : OUT_COUNT_WIDTH;

    localparam logic [15:0] DETECT_WINDOW_RESET = 16'd1000;

    // Surrogate ranges
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST  = 16'hDFFF;

    // ASCII class limits
    localparam logic [15:0] ASCII_LAST     = 16'h007F;
    localparam logic [15:0] PRINT_LAST     = 16'h007E; // '~'
    localparam logic [15:0] PRINT_FIRST    = 16'h0020;
    localparam logic [15:0] SPACE_FIRST    = 16'h0009; // '\t'
    localparam logic [15:0] SPACE_LAST     = 16'h000D; // '\r'

    // Byte order mark bytes
    localparam logic [7:0] BOM_BYTE_FF = 8'hFF;
    localparam logic [7:0] BOM_BYTE_FE = 8'hFE;

    // Result status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_BAD_SURR = 2'd2;

    // Byte order mark modes
    localparam logic [1:0] BOM_NONE = 2'd0;
    localparam logic [1:0] BOM_LE   = 2'd1;
    localparam logic [1:0] BOM_BE   = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Kind of one code unit, one-hot
    typedef enum logic [2:0] {
        UT_CHAR = 3'b001,
        UT_HIGH = 3'b010,
        UT_LOW  = 3'b100
    } unit_type_t;

    // Updated state of one byte-order checker
    typedef struct packed {
        logic       failed;
        unit_type_t prev;
        count_t     normal;
        count_t     weird;
        count_t     chars;
    } chk_stat_t;

    // Decoded step from the byte-order detector
    typedef struct packed {
        logic        check;
        logic [15:0] le_unit;
        logic [15:0] be_unit;
        logic        big_sel;
        logic        odd_end;
    } det_t;

    function automatic logic plain_ascii(logic [15:0] u);
        plain_ascii = ((u >= PRINT_FIRST) && (u <= PRINT_LAST)) ||
                      ((u >= SPACE_FIRST) && (u <= SPACE_LAST));
    endfunction

    function automatic unit_type_t kind_of(logic [15:0] u);
        if (u < HIGH_SURR_BASE)
            kind_of = UT_CHAR;
        else if (u < LOW_SURR_BASE)
            kind_of = UT_HIGH;
        else if (u <= LOW_SURR_LAST)
            kind_of = UT_LOW;
        else
            kind_of = UT_CHAR;
    endfunction

    function automatic count_t sat_inc(count_t v);
        sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [OUT_COUNT_WIDTH-1:0] out_count(count_t v);
        logic [CMP_WIDTH-1:0] w;
        w = CMP_WIDTH'(v);
        if (w > CMP_WIDTH'({OUT_COUNT_WIDTH{1'b1}}))
            out_count = '1;
        else
            out_count = w[OUT_COUNT_WIDTH-1:0];
    endfunction

endpackage

// ----- sv/utf16_stream_validator_unit.sv -----
// ----------------------------------------------------------------------------
// utf16_stream_validator_unit
// UTF-16 text validator with byte order detection and character counts.
// ----------------------------------------------------------------------------
// Input channel: one text byte per request (text_byte, last_byte), moved
// when in_valid is high and in_stall is low. last_byte marks the final
// byte of a text. Output channel: one result request per text (status,
// big_endian and three counts), moved when out_valid is high and
// out_stall is low. cfg_wr_en/cfg_wr_data write detect_window; the user
// must write it only while idle, the block itself does not enforce this.
// Throughput is one byte per cycle while in_stall is low: an input
// register feeds the byte pairing, order detection and both byte-order
// checkers, which update in the same cycle and load the result register.
// in_stall rises only while a finished result waits in the result register
// under out_stall and the next last byte is ready to replace it; other
// bytes keep flowing. Reset clears all text state, empties both stages
// and sets detect_window to 1000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf16_stream_validator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        big_endian,
    output logic [31:0] normal_ascii_count,
    output logic [31:0] weird_ascii_count,
    output logic [31:0] character_count
);
    import utf16sv_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        res_valid_reg, res_valid_next;
    logic [1:0]  res_status_reg;
    logic        res_big_reg;
    logic [OUT_COUNT_WIDTH-1:0] res_normal_reg;
    logic [OUT_COUNT_WIDTH-1:0] res_weird_reg;
    logic [OUT_COUNT_WIDTH-1:0] res_chars_reg;

    logic      res_free;
    logic      s1_adv;
    logic      in_take;
    logic      text_end;
    det_t      det;
    chk_stat_t le_stat;
    chk_stat_t be_stat;
    chk_stat_t sel_stat;

    // Advance the input stage unless a result has nowhere to go
    assign res_free = !res_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || res_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;
    assign text_end = s1_adv && s1_last_reg;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Capture the input request
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
    end

    utf16sv_detect u_detect (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (s1_adv),
        .text_byte   (s1_byte_reg),
        .last_byte   (s1_last_reg),
        .det         (det)
    );

    utf16sv_checker u_check_le (
        .clk      (clk),
        .rst_n    (rst_n),
        .check    (det.check),
        .clear    (text_end),
        .unit     (det.le_unit),
        .stat_upd (le_stat)
    );

    utf16sv_checker u_check_be (
        .clk      (clk),
        .rst_n    (rst_n),
        .check    (det.check),
        .clear    (text_end),
        .unit     (det.be_unit),
        .stat_upd (be_stat)
    );

    assign sel_stat = det.big_sel ? be_stat : le_stat;

    // Hold the result until it is taken
    always_comb
    begin
        if (text_end)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Load the chosen checker, or a bad size result on an odd length
    always_ff @(posedge clk)
    begin
        if (text_end)
        begin
            if (det.odd_end)
            begin
                res_status_reg <= ST_BAD_SIZE;
                res_big_reg    <= 1'b0;
                res_normal_reg <= '0;
                res_weird_reg  <= '0;
                res_chars_reg  <= '0;
            end
            else
            begin
                res_status_reg <= (sel_stat.failed || (sel_stat.prev != UT_CHAR))
                                  ? ST_BAD_SURR : ST_VALID;
                res_big_reg    <= det.big_sel;
                res_normal_reg <= out_count(sel_stat.normal);
                res_weird_reg  <= out_count(sel_stat.weird);
                res_chars_reg  <= out_count(sel_stat.chars);
            end
        end
    end

    assign out_valid          = res_valid_reg;
    assign status             = res_status_reg;
    assign big_endian         = res_big_reg;
    assign normal_ascii_count = res_normal_reg;
    assign weird_ascii_count  = res_weird_reg;
    assign character_count    = res_chars_reg;

    // The input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // A bad size result carries zero counts and little endian
    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_BAD_SIZE)) |->
        (!big_endian && (normal_ascii_count == '0) && (weird_ascii_count == '0) &&
         (character_count == '0)))
        else $error("bad size result with nonzero fields");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_VALID) || (status == ST_BAD_SIZE) ||
                       (status == ST_BAD_SURR)))
        else $error("undefined status code");

    // Normal and weird units never exceed the character count unsaturated
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character_count != '1)) |->
        ((33'(normal_ascii_count) + 33'(weird_ascii_count)) <= 33'(character_count)))
        else $error("ASCII counts exceed character count");

endmodule

// ----- sv/utf16sv_checker.sv -----
// ----------------------------------------------------------------------------
// utf16sv_checker
// Surrogate pairing check and saturating counters for one byte order.
// ----------------------------------------------------------------------------
module utf16sv_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   check,
    input  logic                   clear,
    input  logic [15:0]            unit,
    output utf16sv_pkg::chk_stat_t stat_upd
);
    import utf16sv_pkg::*;

    chk_stat_t  stat_reg;
    chk_stat_t  stat_next;
    unit_type_t kind;

    // Update pairing state and counts for one code unit
    always_comb
    begin
        stat_upd = stat_reg;
        kind     = kind_of(unit);
        if (check && !stat_reg.failed)
        begin
            unique case (kind)
                UT_CHAR:
                begin
                    if (stat_reg.prev != UT_CHAR)
                    begin
                        stat_upd.failed = 1'b1;
                    end
                    else
                    begin
                        if (unit <= ASCII_LAST)
                        begin
                            if (plain_ascii(unit))
                                stat_upd.normal = sat_inc(stat_reg.normal);
                            else
                                stat_upd.weird = sat_inc(stat_reg.weird);
                        end
                        stat_upd.chars = sat_inc(stat_reg.chars);
                    end
                end
                UT_HIGH:
                begin
                    if (stat_reg.prev == UT_HIGH)
                        stat_upd.failed = 1'b1;
                    else
                        stat_upd.prev = UT_HIGH;
                end
                UT_LOW:
                begin
                    if (stat_reg.prev != UT_HIGH)
                    begin
                        stat_upd.failed = 1'b1;
                    end
                    else
                    begin
                        stat_upd.chars = sat_inc(stat_reg.chars);
                        stat_upd.prev  = UT_CHAR;
                    end
                end
                default:
                begin
                    stat_upd.failed = 1'b1;
                end
            endcase
        end
    end

    // Drop all state at the end of a text
    always_comb
    begin
        if (clear)
        begin
            stat_next        = '0;
            stat_next.prev   = UT_CHAR;
        end
        else
        begin
            stat_next = stat_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '{failed: 1'b0, prev: UT_CHAR, default: '0};
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

endmodule

// ----- sv/utf16sv_detect.sv -----
// ----------------------------------------------------------------------------
// utf16sv_detect
// Byte pairing, byte order mark detection and byte order scoring window.
// ----------------------------------------------------------------------------
module utf16sv_detect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              last_byte,
    output utf16sv_pkg::det_t det
);
    import utf16sv_pkg::*;

    logic        phase_reg,      phase_next;
    logic [7:0]  held_reg,       held_next;
    logic        first_done_reg, first_done_next;
    logic [1:0]  bom_reg,        bom_next;
    logic [15:0] win_units_reg,  win_units_next;
    logic [15:0] le_score_reg,   le_score_next;
    logic [15:0] be_score_reg,   be_score_next;
    logic [15:0] window_reg;

    logic        pair;
    logic        bom_le;
    logic        bom_be;
    logic        score;
    logic [1:0]  bom_upd;
    logic [15:0] le_upd;
    logic [15:0] be_upd;
    logic [15:0] le_unit;
    logic [15:0] be_unit;

    // Hold the window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= DETECT_WINDOW_RESET;
        else if (cfg_wr_en)
            window_reg <= cfg_wr_data;
    end

    // Form both readings of a byte pair and look for a mark
    always_comb
    begin
        pair    = step && phase_reg;
        le_unit = {text_byte, held_reg};
        be_unit = {held_reg, text_byte};
        bom_le  = !first_done_reg && (held_reg == BOM_BYTE_FF) && (text_byte == BOM_BYTE_FE);
        bom_be  = !first_done_reg && (held_reg == BOM_BYTE_FE) && (text_byte == BOM_BYTE_FF);

        if (pair && bom_le)
            bom_upd = BOM_LE;
        else if (pair && bom_be)
            bom_upd = BOM_BE;
        else
            bom_upd = bom_reg;

        det.check   = pair && !bom_le && !bom_be;
        det.le_unit = le_unit;
        det.be_unit = be_unit;
        det.odd_end = step && !phase_reg && last_byte;

        // Score both readings within the window
        score  = det.check && (bom_reg == BOM_NONE) && (win_units_reg < window_reg);
        le_upd = le_score_reg + 16'(score && plain_ascii(le_unit));
        be_upd = be_score_reg + 16'(score && plain_ascii(be_unit));

        priority if (bom_upd == BOM_LE)
            det.big_sel = 1'b0;
        else if (bom_upd == BOM_BE)
            det.big_sel = 1'b1;
        else
            det.big_sel = be_upd > le_upd;
    end

    // Advance pairing state, clear at the end of a text
    always_comb
    begin
        phase_next      = phase_reg;
        held_next       = held_reg;
        first_done_next = first_done_reg;
        bom_next        = bom_reg;
        win_units_next  = win_units_reg;
        le_score_next   = le_score_reg;
        be_score_next   = be_score_reg;
        if (step && last_byte)
        begin
            phase_next      = 1'b0;
            held_next       = '0;
            first_done_next = 1'b0;
            bom_next        = BOM_NONE;
            win_units_next  = '0;
            le_score_next   = '0;
            be_score_next   = '0;
        end
        else if (step)
        begin
            phase_next = !phase_reg;
            if (!phase_reg)
                held_next = text_byte;
            first_done_next = first_done_reg || pair;
            bom_next        = bom_upd;
            win_units_next  = win_units_reg + 16'(score);
            le_score_next   = le_upd;
            be_score_next   = be_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            held_reg       <= '0;
            first_done_reg <= 1'b0;
            bom_reg        <= BOM_NONE;
            win_units_reg  <= '0;
            le_score_reg   <= '0;
            be_score_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            first_done_reg <= first_done_next;
            bom_reg        <= bom_next;
            win_units_reg  <= win_units_next;
            le_score_reg   <= le_score_next;
            be_score_reg   <= be_score_next;
        end
    end

endmodule
